// ===== sv/lbg_pkg.sv =====
// Shared types and constants for the LED bar graph level driver.
package lbg_pkg;

   localparam int DUTY_LOG2 = 3;

   localparam logic [15:0] BLINK_PERIOD_RESET = 16'd8192;
   localparam logic [15:0] DUTY_MASK          = 16'((1 << DUTY_LOG2) - 1);

   localparam logic        ACTION_TICK = 1'b0;
   localparam logic        ACTION_SET  = 1'b1;

   localparam logic [4:0]  LEVEL_MAX   = 5'd21;
   localparam logic [4:0]  LEVEL_SPAN  = 5'd10;

   typedef struct packed {
      logic               action;
      logic signed [15:0] temperature;
   } req_type;

   typedef struct packed {
      logic [9:0] led_pattern;
      logic       low_bank_on;
      logic       high_bank_on;
   } rsp_type;

   typedef struct packed {
      logic [4:0] level;
      logic       blink_phase;
      logic       show;
   } bar_ctrl_type;

endpackage

// ===== sv/lbg_level_map.sv =====
// Rounds a reading in sixteenths of a degree and maps it to a bar level.
module lbg_level_map
   import lbg_pkg::*;
(
   input  logic signed [15:0] temperature,
   output logic [4:0]         level
);

   logic signed [16:0] biased;
   logic signed [12:0] rounded;

   // Round to nearest: add half a unit, then floor divide by 16.
   assign biased  = 17'(temperature) + 17'sd8;
   assign rounded = 13'(biased >>> 4);

   always_comb begin
      if (rounded <= 13'sd10) begin
         level = 5'd0;
      end else if (rounded > 13'sd30) begin
         level = LEVEL_MAX;
      end else begin
         level = 5'(rounded - 13'sd10);
      end
   end

endmodule

// ===== sv/lbg_bar_encode.sv =====
// Turns a level and the blink phase into the bar pattern and bank selects.
module lbg_bar_encode
   import lbg_pkg::*;
(
   input  bar_ctrl_type ctrl,
   output rsp_type      rsp
);

   logic [4:0] count;

   always_comb begin
      rsp   = '0;
      count = '0;
      if (ctrl.show) begin
         if (ctrl.level == 5'd0) begin
            rsp.led_pattern = {9'd0, ctrl.blink_phase};
            rsp.low_bank_on = 1'b1;
         end else if (ctrl.level <= LEVEL_SPAN) begin
            rsp.led_pattern = 10'((11'd1 << ctrl.level) - 11'd1);
            rsp.low_bank_on = 1'b1;
         end else if (ctrl.level < LEVEL_MAX) begin
            count            = ctrl.level - LEVEL_SPAN;
            rsp.led_pattern  = 10'((11'd1 << count) - 11'd1);
            rsp.high_bank_on = 1'b1;
         end else begin
            // Top of range: nine solid, top LED blinks.
            rsp.led_pattern  = {ctrl.blink_phase, 9'h1FF};
            rsp.high_bank_on = 1'b1;
         end
      end
   end

endmodule

// ===== sv/led_bar_graph_level_driver_top.sv =====
// Top level of the LED bar graph level driver: state, handshakes, result register.
//
// Usage:
//   req channel (req_valid/req_ready/req_data) carries one item per transfer.
//   action = set stores a new level from the temperature reading and gives
//   no result. action = tick advances the blink divider and gives exactly
//   one result on the rsp channel (rsp_valid/rsp_ready/rsp_data).
//   csr channel writes blink_half_period; csr_ready is always high. Write it
//   only while no tick result is pending.
// Latency and throughput:
//   A tick's result is registered and valid in the cycle after its transfer. One
//   item is taken every cycle while no result waits on a low rsp_ready; all work
//   happens in one pass between the request handshake and the result register.
// Reset:
//   Synchronous, active high. Level, divider and blink phase clear, the
//   period returns to 8192 and no result is pending.
// Stall:
//   While a result waits and rsp_ready is low, req_ready drops and the
//   result holds. When rsp_ready is high a new item is taken in the same
//   cycle the waiting result transfers.
module led_bar_graph_level_driver_top
   import lbg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic [15:0]  period_ff, period_in;
   logic [4:0]   level_ff, level_in;
   logic [15:0]  divider_ff, divider_in;
   logic         blink_ff, blink_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   logic         accept;
   logic         tick_accept;
   logic         set_accept;
   logic [16:0]  divider_inc;
   logic [4:0]   mapped_level;
   bar_ctrl_type bar_ctrl;
   rsp_type      bar_rsp;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign csr_ready   = 1'b1;
   assign accept      = req_valid && req_ready;
   assign tick_accept = accept && (req_data.action == ACTION_TICK);
   assign set_accept  = accept && (req_data.action == ACTION_SET);

   lbg_level_map u_level_map (
      .temperature (req_data.temperature),
      .level       (mapped_level)
   );

   assign divider_inc = {1'b0, divider_ff} + 17'd1;

   always_comb begin
      period_in  = period_ff;
      level_in   = level_ff;
      divider_in = divider_ff;
      blink_in   = blink_ff;
      if (csr_valid && csr_ready) begin
         period_in = csr_data;
      end
      if (set_accept) begin
         level_in = mapped_level;
      end
      if (tick_accept) begin
         // Wrap and toggle once the period is reached.
         if (divider_inc >= {1'b0, period_ff}) begin
            divider_in = '0;
            blink_in   = !blink_ff;
         end else begin
            divider_in = divider_inc[15:0];
         end
      end
   end

   assign bar_ctrl.level       = level_ff;
   assign bar_ctrl.blink_phase = blink_in;
   assign bar_ctrl.show        = (divider_in & DUTY_MASK) == 16'd0;

   lbg_bar_encode u_bar_encode (
      .ctrl (bar_ctrl),
      .rsp  (bar_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (tick_accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = bar_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= BLINK_PERIOD_RESET;
         level_ff     <= '0;
         divider_ff   <= '0;
         blink_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         level_ff     <= level_in;
         divider_ff   <= divider_in;
         blink_ff     <= blink_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_tick_gives_result: assert property (@(posedge clock) disable iff (reset)
      tick_accept |=> rsp_valid_ff)
      else $error("tick transfer did not produce a result");

   a_set_gives_none: assert property (@(posedge clock) disable iff (reset)
      set_accept |=> (rsp_valid_ff == $past(rsp_valid_ff && !rsp_ready)))
      else $error("set transfer changed result occupancy");

   a_divider_bound: assert property (@(posedge clock) disable iff (reset)
      tick_accept |=> (divider_ff == 16'd0 || divider_ff < $past(period_ff)))
      else $error("divider left at or above the blink period");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_MAX)
      else $error("level out of range");

   a_one_bank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.low_bank_on && rsp_data_ff.high_bank_on))
      else $error("both banks enabled");

   a_blink_on_tick: assert property (@(posedge clock) disable iff (reset)
      !tick_accept |=> $stable(blink_ff))
      else $error("blink phase changed without a tick");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the LED bar graph level driver.
`timescale 1ns / 100ps

module tb;
   import lbg_pkg::*;

   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES = 5;
   localparam int ROUND_LOW = 10;
   localparam int ROUND_HIGH = 30;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   // expected bar state, kept in step with the block
   logic [15:0] blink_period = BLINK_PERIOD_RESET;
   logic [4:0]  bar_level = '0;
   logic [15:0] tick_count = '0;
   logic        blink_on = 1'b0;

   rsp_type     expected_bars[$];
   int unsigned errors = 0;
   int unsigned quiet = 0;
   int unsigned rx_hold = 0;
   bit          no_gaps = 1'b0;

   led_bar_graph_level_driver_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned idle_len();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (no_gaps || pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic logic [4:0] level_of(logic signed [15:0] reading);
      int whole;
      whole = (int'(reading) + 8) >>> 4;
      if (whole <= ROUND_LOW) return '0;
      if (whole > ROUND_HIGH) return LEVEL_MAX;
      return 5'(whole - ROUND_LOW);
   endfunction

   function automatic rsp_type bar_of(logic [4:0] lvl, logic phase);
      rsp_type     bar;
      logic [4:0]  lit;
      logic [10:0] ones;
      bar = '0;
      lit = lvl;
      bar.low_bank_on = 1'b1;
      if (lit > LEVEL_SPAN) begin
         lit = lit - LEVEL_SPAN;
         bar.low_bank_on = 1'b0;
         bar.high_bank_on = 1'b1;
      end
      if (lit > LEVEL_SPAN) begin
         bar.led_pattern[9] = phase;
         lit = 5'd9;
      end
      ones = (11'd1 << lit) - 11'd1;
      if (lit == 0) bar.led_pattern[0] = phase;
      else bar.led_pattern = bar.led_pattern | ones[9:0];
      return bar;
   endfunction

   function automatic void update_bar_state(req_type item);
      logic [16:0] next_count;
      if (item.action == ACTION_SET) begin
         bar_level = level_of(item.temperature);
      end else begin
         next_count = {1'b0, tick_count} + 17'd1;
         if (next_count >= {1'b0, blink_period}) begin
            next_count = '0;
            blink_on = ~blink_on;
         end
         tick_count = next_count[15:0];
         if ((tick_count & DUTY_MASK) != 0) expected_bars.push_back('0);
         else expected_bars.push_back(bar_of(bar_level, blink_on));
      end
   endfunction

   task automatic drive_item(input req_type item);
      int unsigned gap;
      gap = idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      update_bar_state(item);
   endtask

   task automatic send_tick();
      req_type item;
      item = '0;
      item.action = ACTION_TICK;
      item.temperature = 16'($urandom());
      drive_item(item);
   endtask

   task automatic send_reading(input logic signed [15:0] reading);
      req_type item;
      item.action = ACTION_SET;
      item.temperature = reading;
      drive_item(item);
   endtask

   task automatic send_random();
      req_type item;
      item.action = ($urandom_range(0, 3) == 0) ? ACTION_SET : ACTION_TICK;
      if ($urandom_range(0, 3) == 0) item.temperature = 16'($urandom());
      else item.temperature = 16'($urandom_range(100, 520));
      drive_item(item);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_bars.size() != 0) @(posedge clock);
   endtask

   task automatic write_period(input logic [15:0] period);
      wait_drained();
      // a set item may still be in flight
      repeat (3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= period;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      blink_period = period;
   endtask

   task automatic test_default_period();
      repeat (30) send_random();
   endtask

   // period of one shows every tick and flips the blink flag each time
   task automatic test_level_map();
      logic signed [15:0] readings[11];
      readings = '{-16'sd32768, -16'sd9, -16'sd8, 16'sd167, 16'sd168, 16'sd327,
                   16'sd328, 16'sd487, 16'sd488, 16'sd32767, 16'sd0};
      write_period(16'd1);
      foreach (readings[k]) begin
         send_reading(readings[k]);
         send_tick();
         if (readings[k] == 16'sd32767 || readings[k] == 16'sd0) send_tick();
      end
   endtask

   task automatic test_zero_period();
      write_period(16'd0);
      repeat (12) send_random();
   endtask

   // shrink the period below the running divider
   task automatic test_period_cut();
      write_period(16'd1000);
      send_reading(16'sd500);
      repeat (40) send_tick();
      write_period(16'd5);
      repeat (12) send_random();
   endtask

   task automatic test_random_phases();
      logic [15:0] periods[6];
      periods = '{16'hFFFF, 16'd2, 16'd9, 16'd16, 16'd1, 16'd0};
      periods[5] = 16'($urandom_range(3, 40));
      foreach (periods[p]) begin
         write_period(periods[p]);
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < 60; n++) begin
            if (n == 30) wait_drained();
            send_random();
         end
         no_gaps = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (rx_hold != 0) begin
         rsp_ready <= 1'b0;
         rx_hold--;
      end else begin
         rsp_ready <= 1'b1;
         rx_hold = idle_len();
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bars.size() == 0) begin
            $error("unexpected result %h", rsp_data);
            errors++;
         end else begin
            want = expected_bars.pop_front();
            if (rsp_data.led_pattern !== want.led_pattern) begin
               $error("led_pattern: expected %h, got %h", want.led_pattern,
                      rsp_data.led_pattern);
               errors++;
            end
            if (rsp_data.low_bank_on !== want.low_bank_on) begin
               $error("low_bank_on: expected %b, got %b", want.low_bank_on,
                      rsp_data.low_bank_on);
               errors++;
            end
            if (rsp_data.high_bank_on !== want.high_bank_on) begin
               $error("high_bank_on: expected %b, got %b", want.high_bank_on,
                      rsp_data.high_bank_on);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("led_bar_graph_level_driver_top: mismatch");
            $finish;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_default_period();
      test_level_map();
      test_zero_period();
      test_period_cut();
      test_random_phases();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_bars.size() == 0) begin
         $display("led_bar_graph_level_driver_top: match");
      end else begin
         $display("led_bar_graph_level_driver_top: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/lbg_pkg.sv
sv/lbg_level_map.sv
sv/lbg_bar_encode.sv
sv/led_bar_graph_level_driver_top.sv
test/tb.sv
